@@ rtl/core/bmprle_pkg.sv @@
package bmprle_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = 13;
	localparam int ADDR_W        = 24;
	// Pointer reaches the image size itself, one past the last address.
	localparam int PTR_W         = ADDR_W + 1;
	localparam int RESET_WIDTH   = 320;
	localparam int RESET_HEIGHT  = 256;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	// Escape codes following a zero count byte
	localparam logic [7:0] ESC_EOL   = 8'h00;
	localparam logic [7:0] ESC_EOB   = 8'h01;
	localparam logic [7:0] ESC_DELTA = 8'h02;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_image;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] run_address;
		logic [7:0]        run_length;
		logic [7:0]        first_value;
		logic [7:0]        second_value;
		logic              image_done;
	} out_item_t;

	typedef struct packed {
		logic             mode;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_rows;
		logic [PTR_W-1:0] total;
	} cfg_t;

	function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = (v > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : v;
		return r;
	endfunction

endpackage

@@ rtl/core/bmprle_parser.sv @@
module bmprle_parser import bmprle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res
);

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_ESCAPE,
		PH_DX,
		PH_DY,
		PH_ABS,
		PH_PAD
	} phase_t;

	phase_t           phase_q, cur_phase, nxt_phase;
	logic [7:0]       pend_q, cur_pend, nxt_pend;
	logic [7:0]       abs_left_q, cur_abs_left, nxt_abs_left;
	logic             pad_q, cur_pad, nxt_pad;
	logic [7:0]       dx_q, cur_dx, nxt_dx;
	logic [PTR_W-1:0] wp_q, cur_wp, nxt_wp;
	logic [15:0]      line_q, cur_line, nxt_line;
	logic             fin_q, cur_fin, nxt_fin;

	logic             soi;
	logic [7:0]       b;
	logic [7:0]       val_a, val_b;
	logic [PTR_W-1:0] avail;
	logic [7:0]       abs_n;
	logic [8:0]       b_inc;
	logic [15:0]      line_inc;
	logic             eol_done;
	logic [25:0]      eol_prod;
	logic [16:0]      dy_line;
	logic [20:0]      dy_prod;
	logic [25:0]      dy_target;
	logic             dy_done;

	logic             emit;
	logic [7:0]       len_req;
	logic [7:0]       n_clip;
	logic [PTR_W-1:0] wp_run;

	assign soi = item.start_of_image;
	assign b   = item.data_byte;

	// Start of image clears the parse state before this byte is taken.
	assign cur_phase    = soi ? PH_COUNT : phase_q;
	assign cur_pend     = soi ? 8'd0 : pend_q;
	assign cur_abs_left = soi ? 8'd0 : abs_left_q;
	assign cur_pad      = soi ? 1'b0 : pad_q;
	assign cur_dx       = soi ? 8'd0 : dx_q;
	assign cur_wp       = soi ? '0 : wp_q;
	assign cur_line     = soi ? 16'd0 : line_q;
	assign cur_fin      = soi ? 1'b0 : fin_q;

	assign val_a = cfg.mode ? {4'h0, b[7:4]} : b;
	assign val_b = cfg.mode ? {4'h0, b[3:0]} : b;

	assign avail = (cur_wp < cfg.total) ? (cfg.total - cur_wp) : '0;

	always_comb begin
		if (cfg.mode) begin
			abs_n = (cur_abs_left < 8'd2) ? cur_abs_left : 8'd2;
		end else begin
			abs_n = (cur_abs_left < 8'd1) ? cur_abs_left : 8'd1;
		end
	end

	assign b_inc = {1'b0, b} + 9'd1;

	// End of line: the jump lands past the image exactly when the new line is
	// at or past the height, or the row is empty.
	assign line_inc = (cur_line == 16'hFFFF) ? cur_line : (cur_line + 16'd1);
	assign eol_done = (cfg.image_width == '0) || (line_inc >= {3'd0, cfg.image_rows});
	assign eol_prod = {13'd0, line_inc[DIM_W-1:0]} * {13'd0, cfg.image_width};

	assign dy_line   = {1'b0, cur_line} + {9'd0, b};
	assign dy_prod   = {13'd0, b} * {8'd0, cfg.image_width};
	assign dy_target = {1'b0, cur_wp} + {5'd0, dy_prod} + {18'd0, cur_dx};
	assign dy_done   = dy_target >= {1'b0, cfg.total};

	always_comb begin
		nxt_phase    = cur_phase;
		nxt_pend     = cur_pend;
		nxt_abs_left = cur_abs_left;
		nxt_pad      = cur_pad;
		nxt_dx       = cur_dx;
		nxt_wp       = cur_wp;
		nxt_line     = cur_line;
		nxt_fin      = cur_fin;
		res_valid    = 1'b0;
		res          = '0;
		emit         = 1'b0;
		len_req      = cur_pend;
		n_clip       = 8'd0;
		wp_run       = cur_wp;

		if (!cur_fin) begin
			case (cur_phase)
				PH_COUNT: begin
					if (b == 8'd0) begin
						nxt_phase = PH_ESCAPE;
					end else begin
						nxt_pend  = b;
						nxt_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					nxt_phase = PH_COUNT;
					emit      = 1'b1;
					len_req   = cur_pend;
				end
				PH_ESCAPE: begin
					case (b)
						ESC_EOL: begin
							nxt_phase = PH_COUNT;
							nxt_line  = line_inc;
							if (eol_done) begin
								nxt_wp          = cfg.total;
								nxt_fin         = 1'b1;
								res_valid       = 1'b1;
								res.image_done  = 1'b1;
							end else begin
								nxt_wp = eol_prod[PTR_W-1:0];
							end
						end
						ESC_EOB: begin
							nxt_phase      = PH_COUNT;
							nxt_fin        = 1'b1;
							res_valid      = 1'b1;
							res.image_done = 1'b1;
						end
						ESC_DELTA: begin
							nxt_phase = PH_DX;
						end
						default: begin
							nxt_abs_left = b;
							nxt_pad      = cfg.mode ? b_inc[1] : b[0];
							nxt_phase    = PH_ABS;
						end
					endcase
				end
				PH_DX: begin
					nxt_dx    = b;
					nxt_phase = PH_DY;
				end
				PH_DY: begin
					nxt_line  = dy_line[16] ? 16'hFFFF : dy_line[15:0];
					nxt_phase = PH_COUNT;
					if (dy_done) begin
						nxt_wp         = cfg.total;
						nxt_fin        = 1'b1;
						res_valid      = 1'b1;
						res.image_done = 1'b1;
					end else begin
						nxt_wp = dy_target[PTR_W-1:0];
					end
				end
				PH_ABS: begin
					nxt_abs_left = cur_abs_left - abs_n;
					if (nxt_abs_left == 8'd0) begin
						nxt_phase = cur_pad ? PH_PAD : PH_COUNT;
					end
					if (abs_n != 8'd0) begin
						emit    = 1'b1;
						len_req = abs_n;
					end
				end
				PH_PAD: begin
					nxt_phase = PH_COUNT;
				end
				default: begin
					nxt_phase = PH_COUNT;
				end
			endcase

			if (emit) begin
				// Clip the run at the image end.
				n_clip = (avail < {17'd0, len_req}) ? avail[7:0] : len_req;
				wp_run = cur_wp + {17'd0, n_clip};
				res_valid = 1'b1;
				if (n_clip == 8'd0) begin
					nxt_fin        = 1'b1;
					res.image_done = 1'b1;
				end else begin
					nxt_wp           = wp_run;
					nxt_fin          = wp_run >= cfg.total;
					res.run_address  = cur_wp[ADDR_W-1:0];
					res.run_length   = n_clip;
					res.first_value  = val_a;
					res.second_value = val_b;
					res.image_done   = wp_run >= cfg.total;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			pend_q     <= 8'd0;
			abs_left_q <= 8'd0;
			pad_q      <= 1'b0;
			dx_q       <= 8'd0;
			wp_q       <= '0;
			line_q     <= 16'd0;
			fin_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= nxt_phase;
			pend_q     <= nxt_pend;
			abs_left_q <= nxt_abs_left;
			pad_q      <= nxt_pad;
			dx_q       <= nxt_dx;
			wp_q       <= nxt_wp;
			line_q     <= nxt_line;
			fin_q      <= nxt_fin;
		end
	end

endmodule

@@ rtl/core/bmp_rle_run_decoder.sv @@
// Run decoder for RLE8 / RLE4 compressed bitmap pixel data.
//
// Byte channel (byte_valid, byte_stall, byte_data): one compressed byte per
// request; start_of_image on a byte clears the parse state, write pointer,
// line counter and done flag before that byte is decoded.
// Run channel (run_valid, run_stall, run_data): run-write commands with a
// start address, a length and two alternating pixel values; a command with
// zero length and image_done set only reports the end of the image.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): mode, width and
// height; always ready. Write it only while no byte is in flight.
//
// Pipeline: input register, then decode into the output register, which holds
// a command while run_stall is high. Throughput: one byte per cycle while the
// run port does not stall; most bytes give no command. The image size product
// is formed on the configuration write; decode keeps only the small row
// multiplies for end of line and delta.
// Reset: asynchronous, returns RLE8 mode, 320 x 256, parse state cleared.
// Run stall: the output register holds its command; the input register still
// takes one more byte, and byte_stall rises only once both are full.
module bmp_rle_run_decoder import bmprle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  in_item_t         byte_data,
	output logic             run_valid,
	input  logic             run_stall,
	output out_item_t        run_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic             mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [PTR_W-1:0] total_q;
	logic [DIM_W-1:0] cfg_dim;
	logic [25:0]      prod_w;
	logic [25:0]      prod_h;
	cfg_t             cfg;

	logic             valid_s1;
	in_item_t         item_s1;
	logic             advance;
	logic             step;
	logic             res_valid;
	out_item_t        res;
	logic             run_valid_q;
	out_item_t        run_data_q;

	assign cfg_ready = 1'b1;

	// Clamp oversized dimensions and form the image size on the write itself.
	assign cfg_dim = dim_clamp(cfg_data);
	assign prod_w  = {13'd0, cfg_dim} * {13'd0, height_q};
	assign prod_h  = {13'd0, width_q} * {13'd0, cfg_dim};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= DIM_W'(RESET_WIDTH);
			height_q <= DIM_W'(RESET_HEIGHT);
			total_q  <= PTR_W'(RESET_WIDTH * RESET_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE: begin
					mode_q <= cfg_data[0];
				end
				CFG_WIDTH: begin
					width_q <= cfg_dim;
					total_q <= prod_w[PTR_W-1:0];
				end
				CFG_HEIGHT: begin
					height_q <= cfg_dim;
					total_q  <= prod_h[PTR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode        = mode_q;
	assign cfg.image_width = width_q;
	assign cfg.image_rows  = height_q;
	assign cfg.total       = total_q;

	// Advance the input stage whenever the output register is free or drains.
	assign advance    = !run_valid_q || !run_stall;
	assign byte_stall = valid_s1 && !advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	bmprle_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold the command while stalled; drop bytes that give no command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (advance) begin
			run_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			run_data_q <= res;
		end
	end

	assign run_valid = run_valid_q;
	assign run_data  = run_data_q;

endmodule
